// ----- src/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Holds the format codes, the digit cell control word and the digit table.
// ----------------------------------------------------------------------------
package i2a_pkg;

	// Number of BCD digit cells: 2^64 - 1 has twenty decimal digits.
	localparam int NDIG       = 20;
	// Hex digits of a 64-bit value; the cells above these stay zero in hex mode.
	localparam int HEX_DIGITS = 16;
	localparam int VALUE_W    = 64;
	localparam int CNT_W      = 7;

	localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);
	localparam logic [CNT_W-1:0] DIG_COUNT = CNT_W'(NDIG);
	localparam logic [CNT_W-1:0] HEX_COUNT = CNT_W'(HEX_DIGITS);

	localparam logic [1:0] CMD_HEX  = 2'd0;
	localparam logic [1:0] CMD_UNS  = 2'd1;
	localparam logic [1:0] CMD_SGN  = 2'd2;
	// The remaining selector value has no meaning; such items are dropped.
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_BIT,
		OP_DIGIT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     dec;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_X,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// Upper-case hex character of one digit; decimal digits map the same way.
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'h0: c = 8'h30;
			4'h1: c = 8'h31;
			4'h2: c = 8'h32;
			4'h3: c = 8'h33;
			4'h4: c = 8'h34;
			4'h5: c = 8'h35;
			4'h6: c = 8'h36;
			4'h7: c = 8'h37;
			4'h8: c = 8'h38;
			4'h9: c = 8'h39;
			4'hA: c = 8'h41;
			4'hB: c = 8'h42;
			4'hC: c = 8'h43;
			4'hD: c = 8'h44;
			4'hE: c = 8'h45;
			default: c = 8'h46;
		endcase
		return c;
	endfunction

endpackage

// ----- src/integer_to_ascii_formatter_top.sv -----
// Conversion: an accepted item is shifted bit-serially through the digit chain in
// 64 steps; the optional prefix ('0x' in hex, '-' for a negative signed value) and
// the digits follow, subject to output stalls. A new item is taken only once the
// last character of the previous one has been loaded into the output register.
// Reset: arst_n clears the sequencer and the output valid flag asynchronously;
// the digit cells, the shift register and the output character hold payload only and are not reset.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: 64-bit value to ASCII hex or decimal string
// A double-dabble chain of digit cells converts the value, then the same chain
// shifts the digits out one per cycle unless the output stalls, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] ascii_char
	output logic        m_axis_tlast    // last
);

	i2a_pkg::state_t state_q, state_nxt;
	logic [i2a_pkg::CNT_W-1:0]   cnt_q;
	logic                        hex_q;
	logic                        neg_q;
	logic [i2a_pkg::VALUE_W-1:0] bin_q;
	logic                        out_valid_q;
	logic [7:0]                  out_data_q;
	logic                        out_last_q;

	logic        in_acc;
	logic        out_load;
	logic        skip_more;
	logic        emit;
	logic [7:0]  emit_char;
	logic        emit_last;
	logic        in_neg;
	logic [i2a_pkg::VALUE_W-1:0] in_mag;
	i2a_pkg::cell_ctrl_t ctrl;

	logic [3:0]            digit [i2a_pkg::NDIG];
	logic [i2a_pkg::NDIG-1:0] carry;
	logic [3:0]            top_digit;

	// The sequencer takes one item at a time; ready is high only when idle.
	assign s_axis_tready = (state_q == i2a_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// The output register can take a new character when empty or being drained.
	assign out_load = emit && (!out_valid_q || m_axis_tready);

	// Signed mode negates a negative value; the most negative value gives 2^63
	// as an unsigned magnitude, which is exactly what the chain needs.
	assign in_neg = (s_axis_tuser == i2a_pkg::CMD_SGN) && s_axis_tdata[i2a_pkg::VALUE_W-1];
	assign in_mag = in_neg ? (~s_axis_tdata + 64'd1) : s_axis_tdata;

	assign top_digit = digit[i2a_pkg::NDIG-1];

	// Hex mode drops the four always-zero upper cells; decimal drops leading
	// zeros but keeps the last digit, so zero prints as a single '0'.
	assign skip_more = hex_q ? (cnt_q > i2a_pkg::HEX_COUNT)
	                         : ((top_digit == 4'd0) && (cnt_q > 7'd1));

	// Digit chain: cell 0 takes the next bit of the value, every cell hands
	// its carry and its digit up to the next one.
	for (genvar i = 0; i < i2a_pkg::NDIG; i++) begin : g_cell
		logic       b_in;
		logic [3:0] d_in;
		if (i == 0) begin : g_first
			assign b_in = bin_q[i2a_pkg::VALUE_W-1];
			assign d_in = 4'd0;
		end else begin : g_rest
			assign b_in = carry[i-1];
			assign d_in = digit[i-1];
		end
		i2a_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (b_in),
			.digit_in (d_in),
			.bit_out  (carry[i]),
			.digit    (digit[i])
		);
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			i2a_pkg::ST_IDLE: begin
				if (in_acc && (s_axis_tuser != i2a_pkg::CMD_NONE)) begin
					state_nxt = i2a_pkg::ST_CONV;
				end
			end
			i2a_pkg::ST_CONV: begin
				if (cnt_q == 7'd0) begin
					state_nxt = (hex_q || neg_q) ? i2a_pkg::ST_SIGN : i2a_pkg::ST_SKIP;
				end
			end
			i2a_pkg::ST_SIGN: begin
				if (out_load) begin
					state_nxt = hex_q ? i2a_pkg::ST_X : i2a_pkg::ST_SKIP;
				end
			end
			i2a_pkg::ST_X: begin
				if (out_load) begin
					state_nxt = i2a_pkg::ST_SKIP;
				end
			end
			i2a_pkg::ST_SKIP: begin
				if (!skip_more) begin
					state_nxt = i2a_pkg::ST_EMIT;
				end
			end
			i2a_pkg::ST_EMIT: begin
				if (out_load && emit_last) begin
					state_nxt = i2a_pkg::ST_IDLE;
				end
			end
			default: state_nxt = i2a_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: cell control and the character to send.
	always_comb begin
		ctrl.dec  = !hex_q;
		ctrl.op   = i2a_pkg::OP_HOLD;
		emit      = 1'b0;
		emit_char = i2a_pkg::hex_char(top_digit);
		emit_last = 1'b0;
		case (state_q)
			i2a_pkg::ST_IDLE: begin
				if (in_acc) begin
					ctrl.op = i2a_pkg::OP_CLEAR;
				end
			end
			i2a_pkg::ST_CONV: begin
				ctrl.op = i2a_pkg::OP_BIT;
			end
			i2a_pkg::ST_SIGN: begin
				emit      = 1'b1;
				emit_char = hex_q ? i2a_pkg::CH_ZERO : i2a_pkg::CH_MINUS;
			end
			i2a_pkg::ST_X: begin
				emit      = 1'b1;
				emit_char = i2a_pkg::CH_X;
			end
			i2a_pkg::ST_SKIP: begin
				if (skip_more) begin
					ctrl.op = i2a_pkg::OP_DIGIT;
				end
			end
			i2a_pkg::ST_EMIT: begin
				emit      = 1'b1;
				emit_last = (cnt_q == 7'd1);
				if (out_load) begin
					ctrl.op = i2a_pkg::OP_DIGIT;
				end
			end
			default: ctrl.op = i2a_pkg::OP_HOLD;
		endcase
	end

	// Control registers: state, step counter and mode flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
			cnt_q   <= '0;
			hex_q   <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				cnt_q <= i2a_pkg::CONV_LAST;
				hex_q <= (s_axis_tuser == i2a_pkg::CMD_HEX);
				neg_q <= in_neg;
			end else if (state_q == i2a_pkg::ST_CONV) begin
				cnt_q <= (cnt_q == 7'd0) ? i2a_pkg::DIG_COUNT : (cnt_q - 7'd1);
			end else if (ctrl.op == i2a_pkg::OP_DIGIT) begin
				// The counter now holds the number of digits left in the chain.
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	// Value shift register feeding cell 0 most significant bit first.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bin_q <= in_mag;
		end else if (state_q == i2a_pkg::ST_CONV) begin
			bin_q <= {bin_q[i2a_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	// Output register: holds one character while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_last) |=> (state_q == i2a_pkg::ST_IDLE))
		else $error("last character did not return the sequencer to idle");

	a_conv_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == i2a_pkg::ST_CONV) && (cnt_q != 7'd0)) |=>
		((state_q == i2a_pkg::ST_CONV) && (cnt_q == $past(cnt_q) - 7'd1)))
		else $error("conversion counter did not step down");

	a_digits_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == i2a_pkg::ST_SKIP) || (state_q == i2a_pkg::ST_EMIT)) |->
		((cnt_q != 7'd0) && (cnt_q <= i2a_pkg::DIG_COUNT)))
		else $error("digit count out of range while emitting");

	a_hex_all_digits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == i2a_pkg::ST_EMIT) && hex_q) |-> (cnt_q <= i2a_pkg::HEX_COUNT))
		else $error("hex emission started with upper cells left");
`endif

endmodule

// ----- src/i2a_cell.sv -----
// ----------------------------------------------------------------------------
// i2a_cell: one digit cell of the conversion chain
// Holds one 4-bit digit. Shifts one bit in from its lower neighbor (with the
// add-3 correction in decimal mode) or takes the neighbor's whole digit.
// ----------------------------------------------------------------------------
module i2a_cell (
	input  logic               clk,
	input  i2a_pkg::cell_ctrl_t ctrl,
	input  logic               bit_in,
	input  logic [3:0]         digit_in,
	output logic               bit_out,
	output logic [3:0]         digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	always_comb begin
		adj = (ctrl.dec && (digit_q >= 4'd5)) ? (digit_q + 4'd3) : digit_q;
	end

	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			i2a_pkg::OP_CLEAR: digit_q <= 4'd0;
			i2a_pkg::OP_BIT:   digit_q <= {adj[2:0], bit_in};
			i2a_pkg::OP_DIGIT: digit_q <= digit_in;
			default:           digit_q <= digit_q;
		endcase
	end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the integer to ASCII formatter
// Sends formatting requests in all three modes plus the unused selector, works
// out the expected character strings on the side and compares every character
// and its last marker as it leaves the block, under random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS  = 380;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned DRAIN_CYCLES  = 200;
	localparam int unsigned MAX_REPORTED  = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;     // [63:0] value
	logic [1:0]  s_axis_tuser = i2a_pkg::CMD_HEX; // [1:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // [7:0] ascii_char
	logic        m_axis_tlast;          // last

	// Characters still owed by the block, oldest first.
	text_char_t  pending_text[$];

	int unsigned cycles;
	int unsigned mismatches;
	int unsigned chars_checked;
	int unsigned items_by_cmd [4];
	int unsigned hold_request;

	integer_to_ascii_formatter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog. Also gives the output side a time base for its stall pattern.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still pending",
				cycles, pending_text.size());
			$display("integer_to_ascii_formatter_top test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return i2a_pkg::CH_ZERO + 8'(n);
		end
		return 8'h41 + 8'(n - 4'd10);
	endfunction

	function automatic void push_char(input logic [7:0] ch);
		text_char_t t;
		t.ch = ch;
		t.last = 1'b0;
		pending_text.push_back(t);
	endfunction

	// Decimal digits of a magnitude, most significant first, with a lone '0'
	// for zero.
	function automatic void push_decimal(input logic [63:0] mag);
		logic [7:0] digits [20];
		int         count;
		count = 0;
		if (mag == 64'd0) begin
			push_char(i2a_pkg::CH_ZERO);
			return;
		end
		while (mag != 64'd0) begin
			digits[count] = i2a_pkg::CH_ZERO + 8'(mag % 64'd10);
			mag = mag / 64'd10;
			count++;
		end
		for (int k = count - 1; k >= 0; k--) begin
			push_char(digits[k]);
		end
	endfunction

	// Appends the text that one accepted item must produce and flags the
	// final character. The unused selector produces nothing.
	function automatic void predict_text(input logic [1:0] cmd, input logic [63:0] value);
		text_char_t t;
		case (cmd)
			i2a_pkg::CMD_HEX: begin
				push_char(i2a_pkg::CH_ZERO);
				push_char(i2a_pkg::CH_X);
				for (int n = 15; n >= 0; n--) begin
					push_char(nibble_char(value[n*4 +: 4]));
				end
			end
			i2a_pkg::CMD_UNS: begin
				push_decimal(value);
			end
			i2a_pkg::CMD_SGN: begin
				// Negating the most negative value wraps back to 2^63, which
				// is exactly the magnitude wanted.
				if (value[63]) begin
					push_char(i2a_pkg::CH_MINUS);
					push_decimal(~value + 64'd1);
				end else begin
					push_decimal(value);
				end
			end
			default: begin
				return;
			end
		endcase
		t = pending_text.pop_back();
		t.last = 1'b1;
		pending_text.push_back(t);
	endfunction

	// ------------------------------------------------------------------------
	// Output side: stall pattern, long hold-off, and checking
	// ------------------------------------------------------------------------

	// The stall pattern steps through four modes in turn, on a period chosen so
	// that it drifts against the block's own item period. A test may ask for a
	// long hold-off; it is counted here.
	initial begin : output_stalls
		int unsigned n;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				case ((cycles / 97) % 4)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (cycles % 3 != 0);
				endcase
			end
		end
	end

	task automatic note_mismatch(input string what, input logic [7:0] exp_ch,
			input logic exp_last);
		mismatches++;
		if (mismatches <= MAX_REPORTED) begin
			$display("%0t: %s: expected char %h last %b, got char %h last %b",
				$realtime, what, exp_ch, exp_last, m_axis_tdata, m_axis_tlast);
		end
	endtask

	// Values are sampled at the edge itself, before any register update of
	// that edge lands.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_checked++;
			if (pending_text.size() == 0) begin
				note_mismatch("character with nothing expected", 8'h00, 1'b0);
			end else begin
				want = pending_text.pop_front();
				if (m_axis_tdata !== want.ch) begin
					note_mismatch("wrong character", want.ch, want.last);
				end else if (m_axis_tlast !== want.last) begin
					note_mismatch("wrong last marker", want.ch, want.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Called just after a rising edge. Holds the item until the block takes
	// it, then either keeps valid up for the next item or idles for gap cycles.
	task automatic send_item(input logic [1:0] cmd, input logic [63:0] value,
			input int unsigned gap);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		predict_text(cmd, value);
		items_by_cmd[cmd]++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] ten_to(input int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	// Spreads values over every length of decimal text, with extra
	// weight on digit-count boundaries and on the sign boundary.
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return v;
			1: return 64'($urandom_range(0, 999));
			2: return v >> $urandom_range(0, 63);
			3: return ten_to($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
			4: return -64'($urandom_range(1, 1000));
			default: begin
				if ($urandom_range(0, 1) == 1) begin
					return {1'b1, 63'd0} + 64'($urandom_range(0, 50));
				end
				return {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 50));
			end
		endcase
	endfunction

	function automatic logic [1:0] random_cmd();
		int unsigned r;
		r = $urandom_range(0, 33);
		if (r <= 10) begin
			return i2a_pkg::CMD_HEX;
		end else if (r <= 21) begin
			return i2a_pkg::CMD_UNS;
		end else if (r <= 32) begin
			return i2a_pkg::CMD_SGN;
		end
		return i2a_pkg::CMD_NONE;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes in every mode, decimal length boundaries, the most
	// negative value and the unused selector.
	task automatic test_directed();
		send_item(i2a_pkg::CMD_HEX, 64'd0, 0);
		send_item(i2a_pkg::CMD_HEX, {64{1'b1}}, 3);
		send_item(i2a_pkg::CMD_HEX, 64'h0123_4567_89AB_CDEF, 0);
		send_item(i2a_pkg::CMD_HEX, 64'hFEDC_BA98_7654_3210, 1);
		send_item(i2a_pkg::CMD_HEX, 64'h8000_0000_0000_0000, 0);
		send_item(i2a_pkg::CMD_UNS, 64'd0, 0);
		send_item(i2a_pkg::CMD_UNS, 64'd9, 2);
		send_item(i2a_pkg::CMD_UNS, 64'd10, 0);
		send_item(i2a_pkg::CMD_UNS, {64{1'b1}}, 0);
		send_item(i2a_pkg::CMD_UNS, ten_to(19), 5);
		send_item(i2a_pkg::CMD_UNS, ten_to(19) - 64'd1, 0);
		send_item(i2a_pkg::CMD_SGN, 64'd0, 0);
		send_item(i2a_pkg::CMD_SGN, {64{1'b1}}, 0);
		send_item(i2a_pkg::CMD_SGN, 64'h8000_0000_0000_0000, 7);
		send_item(i2a_pkg::CMD_SGN, 64'h7FFF_FFFF_FFFF_FFFF, 0);
		send_item(i2a_pkg::CMD_SGN, -64'd10, 0);
		send_item(i2a_pkg::CMD_SGN, 64'd42, 0);
		send_item(i2a_pkg::CMD_NONE, 64'd123, 0);
		send_item(i2a_pkg::CMD_NONE, {64{1'b1}}, 4);
		send_item(i2a_pkg::CMD_UNS, 64'd7, 0);
		send_item(i2a_pkg::CMD_NONE, 64'd0, 0);
		send_item(i2a_pkg::CMD_HEX, 64'h0000_0000_0000_00A5, 0);
	endtask

	// Items offered without any gap in the three modes.
	task automatic test_back_to_back();
		for (int i = 0; i < 9; i++) begin
			send_item(2'(i % 3), random_value(), 0);
		end
	endtask

	// The output side holds off for a long stretch while items keep coming,
	// so the block backs up to its input.
	task automatic test_output_hold_off();
		hold_request = 400;
		for (int i = 0; i < 6; i++) begin
			send_item(2'(i % 3), random_value(), 0);
		end
	endtask

	// Random modes and values, sent in bursts with idle stretches of random
	// length between them.
	task automatic test_random();
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		logic [1:0]  cmd;
		sent = 0;
		burst = $urandom_range(1, 12);
		while (sent < RANDOM_ITEMS) begin
			cmd = random_cmd();
			gap = 0;
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
					: $urandom_range(1, 20);
			end
			send_item(cmd, random_value(), gap);
			if (cmd != i2a_pkg::CMD_NONE) begin
				sent++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_back_to_back();
		test_output_hold_off();
		test_random();

		s_axis_tvalid <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_text.size() != 0) begin
			mismatches++;
		end

		$display("items sent: %0d hex, %0d unsigned, %0d signed, %0d with unused selector",
			items_by_cmd[i2a_pkg::CMD_HEX], items_by_cmd[i2a_pkg::CMD_UNS],
			items_by_cmd[i2a_pkg::CMD_SGN], items_by_cmd[i2a_pkg::CMD_NONE]);
		$display("characters checked: %0d, mismatches: %0d, cycles: %0d",
			chars_checked, mismatches, cycles);
		if (mismatches == 0) begin
			$display("integer_to_ascii_formatter_top test passed");
		end else begin
			$display("integer_to_ascii_formatter_top test failed");
		end
		$finish;
	end

endmodule
